### hdl/macd_pkg.sv
// Shared types and constants for the moving average crossover detector.
// Used by the top level and by its port checker; depends on nothing else.
package macd_pkg;

  localparam int PRICE_W = 24;            // price and average width
  localparam int WIN_W = 9;               // width of a window length register
  localparam int CFG_IDX_W = 2;           // width of the register index on the write port
  localparam int IN_W = 24;               // input tdata width
  localparam int OUT_W = 56;              // output tdata width, whole bytes
  localparam int OUT_PAD_W = OUT_W - 2 * PRICE_W - 3;

  // Output tdata bit positions.
  localparam int OUT_VALID_BIT = 2 * PRICE_W;
  localparam int OUT_BELOW_BIT = 2 * PRICE_W + 1;
  localparam int OUT_ABOVE_BIT = 2 * PRICE_W + 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG = 2'd1;

  // Reset values of the window length registers.
  localparam logic [WIN_W-1:0] SHORT_RESET = 9'd5;
  localparam logic [WIN_W-1:0] LONG_RESET = 9'd20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_S,
    S_RD_L,
    S_UPDATE,
    S_LOAD_S,
    S_DIV_S,
    S_LOAD_L,
    S_DIV_L,
    S_DONE
  } state_t;

endpackage

### hdl/macd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Holds the price history ring of the crossover detector; no dependencies.
module macd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/moving_average_crossover_detector.sv
// Top level of the moving average crossover detector: history RAM, running sums,
// a shared restoring divider and the sequencer. Depends on macd_pkg and macd_ram.
//
// Usage. Price samples arrive on the slave stream (s_tvalid, s_tready, s_tdata);
// one request is taken when s_tvalid and s_tready are both high at a clock edge.
// Every accepted sample produces exactly one result on the master stream
// (m_tvalid, m_tready, m_tdata): the rounded short and long averages, a flag
// that both windows are full, and the downward and upward crossing flags.
// Window lengths are set through the write port (cfg_we, cfg_index, cfg_data);
// a write restarts accumulation, and it is meant to happen only while idle.
// Sequence. After acceptance the sequencer reads the two history slots, updates
// the sums, then loads and runs the single divider for each average whose window
// is full, at one quotient bit a cycle, and hands the result to the output
// register; s_tready rises together with the result, so the block takes no new
// sample before it is through with the last. An average whose window is not yet
// full is given as zero without a division.
// The result sits in an output register, so a new sample is accepted while the
// previous result still waits; if the receiver stalls, the sequencer holds the
// finished result in its last state until the output register frees up.
// Reset (rst, synchronous) restores lengths 5 and 20 and clears sums, count, pointer and
// the pending result. The history RAM is not cleared; it is only read where written.
module moving_average_crossover_detector #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  // Slave stream. s_tdata: price [23:0].
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [macd_pkg::IN_W-1:0]      s_tdata,
  // Master stream. m_tdata: short_average [23:0], long_average [47:24],
  // both_valid [48], cross_below [49], cross_above [50], zero fill [55:51].
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [macd_pkg::OUT_W-1:0]     m_tdata,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [macd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [macd_pkg::WIN_W-1:0]     cfg_data
);

  localparam int PW = macd_pkg::PRICE_W;
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = PW + PTR_W;      // holds MAX_WINDOW full-scale prices
  localparam int DV_W = SUM_W + 2;        // 2*sum + len
  localparam int RW = CNT_W + 2;          // divider remainder, below twice 2*len
  localparam int STEP_W = $clog2(PW);

  // Effective window length: zero reads as one, long values saturate.
  function automatic logic [CNT_W-1:0] eff_len(input logic [macd_pkg::WIN_W-1:0] r);
    logic [CNT_W-1:0] len;
    if (r == '0) begin
      len = CNT_W'(1);
    end else if (32'(r) > 32'(MAX_WINDOW)) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(r);
    end
    return len;
  endfunction

  macd_pkg::state_t state, state_next;

  logic [macd_pkg::WIN_W-1:0] short_window, long_window;
  logic [SUM_W-1:0] short_sum, long_sum;
  logic [CNT_W-1:0] sample_count;
  logic [PTR_W-1:0] write_pointer;
  logic prev_short_below, prev_valid;

  logic [PW-1:0] price_q;
  logic [PW-1:0] old_short;
  logic [PW-1:0] short_avg, long_avg;

  // Divider registers: the dividend's low bits shift out as quotient bits shift in.
  logic [RW-1:0] rem, divisor;
  logic [PW-1:0] dvd;
  logic [STEP_W-1:0] step;

  logic [CNT_W-1:0] len_s, len_l;
  logic [PTR_W-1:0] slot_s, slot_l;
  logic s_full, l_full, s_drop, l_drop;
  logic out_free, accept, last_step;

  logic ram_we;
  logic [PTR_W-1:0] ram_rd_addr;
  logic [PW-1:0] ram_rd_data;

  logic [SUM_W-1:0] sel_sum;
  logic [CNT_W-1:0] sel_len;
  logic [DV_W-1:0] dividend;
  logic [RW-1:0] rem_sh;
  logic q_bit;
  logic [PW-1:0] quotient;
  logic below, both_valid, cross_below, cross_above;

  // Ring slot that lies len samples behind the write pointer.
  function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] wp,
                                                 input logic [CNT_W-1:0] len);
    logic [PTR_W:0] t;
    t = {1'b0, wp} + (PTR_W + 1)'(MAX_WINDOW) - (PTR_W + 1)'(len);
    if (t >= (PTR_W + 1)'(MAX_WINDOW)) begin
      t = t - (PTR_W + 1)'(MAX_WINDOW);
    end
    return t[PTR_W-1:0];
  endfunction

  assign len_s = eff_len(short_window);
  assign len_l = eff_len(long_window);
  assign slot_s = slot_back(write_pointer, len_s);
  assign slot_l = slot_back(write_pointer, len_l);

  // Before the update the count tells which samples leave; afterwards, fullness.
  assign s_drop = sample_count >= len_s;
  assign l_drop = sample_count >= len_l;
  assign s_full = sample_count >= len_s;
  assign l_full = sample_count >= len_l;

  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign last_step = step == STEP_W'(PW - 1);

  // Divider front end: operands for whichever average is loaded now.
  assign sel_sum = (state == macd_pkg::S_LOAD_L) ? long_sum : short_sum;
  assign sel_len = (state == macd_pkg::S_LOAD_L) ? len_l : len_s;
  assign dividend = {1'b0, sel_sum, 1'b0} + DV_W'(sel_len);

  // One restoring division step.
  assign rem_sh = {rem[RW-2:0], dvd[PW-1]};
  assign q_bit = rem_sh >= divisor;
  assign quotient = {dvd[PW-2:0], q_bit};

  assign below = short_avg < long_avg;
  assign both_valid = s_full && l_full;
  assign cross_below = both_valid && prev_valid && !prev_short_below && below;
  assign cross_above = both_valid && prev_valid && prev_short_below && !below;

  macd_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_WINDOW)
  ) u_history (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(write_pointer),
    .wr_data(price_q),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= macd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    ram_we = 1'b0;
    ram_rd_addr = slot_s;
    case (state)
      macd_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = macd_pkg::S_RD_S;
        end
      end
      macd_pkg::S_RD_S: begin
        state_next = macd_pkg::S_RD_L;
      end
      macd_pkg::S_RD_L: begin
        ram_rd_addr = slot_l;
        state_next = macd_pkg::S_UPDATE;
      end
      macd_pkg::S_UPDATE: begin
        ram_we = 1'b1;
        state_next = macd_pkg::S_LOAD_S;
      end
      macd_pkg::S_LOAD_S: begin
        state_next = s_full ? macd_pkg::S_DIV_S : macd_pkg::S_LOAD_L;
      end
      macd_pkg::S_DIV_S: begin
        if (last_step) begin
          state_next = macd_pkg::S_LOAD_L;
        end
      end
      macd_pkg::S_LOAD_L: begin
        state_next = l_full ? macd_pkg::S_DIV_L : macd_pkg::S_DONE;
      end
      macd_pkg::S_DIV_L: begin
        if (last_step) begin
          state_next = macd_pkg::S_DONE;
        end
      end
      macd_pkg::S_DONE: begin
        if (out_free) begin
          state_next = macd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = macd_pkg::S_IDLE;
      end
    endcase
  end

  // Control state: window lengths, sums, count, pointer, crossing history and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_window <= macd_pkg::SHORT_RESET;
      long_window <= macd_pkg::LONG_RESET;
      short_sum <= '0;
      long_sum <= '0;
      sample_count <= '0;
      write_pointer <= '0;
      prev_short_below <= 1'b0;
      prev_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == macd_pkg::S_UPDATE) begin
        short_sum <= short_sum - (s_drop ? SUM_W'(old_short) : '0) + SUM_W'(price_q);
        long_sum <= long_sum - (l_drop ? SUM_W'(ram_rd_data) : '0) + SUM_W'(price_q);
        if (sample_count < CNT_W'(MAX_WINDOW)) begin
          sample_count <= sample_count + CNT_W'(1);
        end
        if (write_pointer == PTR_W'(MAX_WINDOW - 1)) begin
          write_pointer <= '0;
        end else begin
          write_pointer <= write_pointer + PTR_W'(1);
        end
      end

      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == macd_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
        if (both_valid) begin
          prev_short_below <= below;
          prev_valid <= 1'b1;
        end
      end

      // A length write restarts accumulation; history and pointer stay.
      if (cfg_we && (cfg_index == macd_pkg::REG_SHORT || cfg_index == macd_pkg::REG_LONG))
      begin
        if (cfg_index == macd_pkg::REG_SHORT) begin
          short_window <= cfg_data;
        end else begin
          long_window <= cfg_data;
        end
        short_sum <= '0;
        long_sum <= '0;
        sample_count <= '0;
        prev_short_below <= 1'b0;
        prev_valid <= 1'b0;
      end
    end
  end

  // Payload and divider registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      price_q <= s_tdata[PW-1:0];
    end
    if (state == macd_pkg::S_RD_L) begin
      old_short <= ram_rd_data;
    end

    case (state)
      macd_pkg::S_LOAD_S, macd_pkg::S_LOAD_L: begin
        // The quotient is known to fit PW bits, so the top bits start below the divisor.
        rem <= RW'(dividend[DV_W-1:PW]);
        dvd <= dividend[PW-1:0];
        divisor <= RW'({sel_len, 1'b0});
        step <= '0;
        if (state == macd_pkg::S_LOAD_S && !s_full) begin
          short_avg <= '0;
        end
        if (state == macd_pkg::S_LOAD_L && !l_full) begin
          long_avg <= '0;
        end
      end
      macd_pkg::S_DIV_S, macd_pkg::S_DIV_L: begin
        rem <= q_bit ? rem_sh - divisor : rem_sh;
        dvd <= quotient;
        step <= step + STEP_W'(1);
        if (last_step && state == macd_pkg::S_DIV_S) begin
          short_avg <= quotient;
        end
        if (last_step && state == macd_pkg::S_DIV_L) begin
          long_avg <= quotient;
        end
      end
      default: begin
      end
    endcase

    if (state == macd_pkg::S_DONE && out_free) begin
      m_tdata <= {{macd_pkg::OUT_PAD_W{1'b0}}, cross_above, cross_below, both_valid,
                  long_avg, short_avg};
    end
  end

endmodule

### hdl/macd_checker.sv
// Port-level checker for the moving average crossover detector, bound to the top level.
// Depends on macd_pkg for the output word width.
module macd_port_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [macd_pkg::OUT_W-1:0] m_tdata
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // One sample at a time: the block is busy right after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

endmodule

bind moving_average_crossover_detector macd_port_checker u_macd_port_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
